// ===== rtl/sfran_pkg.sv =====
// package for the serial frame register access node: types and constants
`default_nettype none
package sfran_pkg;

  localparam int unsigned FrameDataMax  = 16;
  localparam int unsigned RegSpaceBytes = 256;

  localparam logic [7:0] Head1Byte = 8'hFE;
  localparam logic [7:0] Head2Byte = 8'h68;
  localparam logic [7:0] CmdW      = 8'h57;
  localparam logic [7:0] CmdX      = 8'h58;
  localparam logic [7:0] CmdR      = 8'h52;
  localparam logic [7:0] CmdS      = 8'h53;

  typedef enum logic [1:0] {
    OP_BUS   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_NODE  = 1'b0,
    CFG_BCAST = 1'b1
  } cfg_idx_e;

endpackage
`default_nettype wire

// ===== rtl/sfran_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module sfran_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/serial_frame_register_access_node.sv =====
// serial frame register access node: frame parser, executor and reply sender
// a bus byte that only advances the parser, or a local write, is done within ST_IDLE;
// a local read passes ST_LOCRD, where the ram data arrives, then waits in ST_OUT until taken
// a frame checksum byte runs the sequencer: ST_SUM per payload byte to sum, ST_SUMW checks,
// then per W pair ST_EXOFF and ST_EXV1, per X triplet ST_EXOFF to ST_EXV3 (and ST_EXRD), or
// six header bytes in ST_HDR, ST_EXOFF to ST_EXV1 (R) or ST_EXV2 (S) per entry and ST_CKO,
// plus output stalls; one transaction at a time; ready is low while the sequencer runs
// reset: asynchronous, active low; after reset a clearing pass over all RegSpaceBytes entries
// zeroes the register space before the first input transaction is taken
`default_nettype none
module serial_frame_register_access_node #(
  parameter int unsigned FrameDataMax  = sfran_pkg::FrameDataMax,
  parameter int unsigned RegSpaceBytes = sfran_pkg::RegSpaceBytes
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic [7:0] local_offset_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            kind_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  import sfran_pkg::*;

  localparam int unsigned RegAw = $clog2(RegSpaceBytes);
  localparam int unsigned PayAw = (FrameDataMax > 1) ? $clog2(FrameDataMax) : 1;
  localparam int unsigned PayDepth = 1 << PayAw;

  // sequencer states, one-hot
  typedef enum logic [12:0] {
    ST_CLEAR = 13'h0001,  // post-reset clearing pass
    ST_IDLE  = 13'h0002,
    ST_LOCRD = 13'h0004,  // local read, wait for ram data
    ST_SUM   = 13'h0008,  // checksum pass over payload
    ST_SUMW  = 13'h0010,  // checksum and address check, dispatch
    ST_EXRD  = 13'h0020,  // read payload entry j
    ST_EXOFF = 13'h0040,  // offset arrives, start register access
    ST_EXV1  = 13'h0080,  // second payload byte / first register value
    ST_EXV2  = 13'h0100,  // third payload byte / second register value
    ST_EXV3  = 13'h0200,  // write of high byte for X
    ST_HDR   = 13'h0400,  // emit reply header bytes
    ST_CKO   = 13'h0800,  // emit reply checksum
    ST_OUT   = 13'h1000   // local read result held
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEAD1, PH_HEAD2, PH_SRC, PH_DST, PH_CMD, PH_DATA, PH_CKSUM
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [7:0] node_q, bcast_q;
  logic [7:0] src_q, dst_q, cmd_q;
  logic [4:0] len_q, cnt_q;
  logic [7:0] sum_q, sum_d;       // frame checksum
  logic [RegAw:0] clr_q;
  logic [4:0] j_q;                // payload index in execution
  logic [7:0] off_q;              // current offset
  logic [7:0] rsum_q;             // reply checksum accumulator
  logic [2:0] hdr_q;              // reply header byte index
  logic [7:0] rcmd_q;             // reply command code

  // output register
  logic       ovalid_q;
  logic       okind_q, olast_q;
  logic [7:0] obyte_q;

  // payload store ram
  logic             pay_we;
  logic [PayAw-1:0] pay_addr;
  logic [7:0]       pay_wdata, pay_rdata;

  // register space ram
  logic             reg_we;
  logic [RegAw-1:0] reg_addr;
  logic [7:0]       reg_wdata, reg_rdata;

  sfran_ram #(.Width(8), .Depth(PayDepth)) u_pay (
    .clk_i, .we_i(pay_we), .addr_i(pay_addr), .wdata_i(pay_wdata), .rdata_o(pay_rdata)
  );
  sfran_ram #(.Width(8), .Depth(RegSpaceBytes)) u_regs (
    .clk_i, .we_i(reg_we), .addr_i(reg_addr), .wdata_i(reg_wdata), .rdata_o(reg_rdata)
  );

  wire logic in_acc  = in_valid_i & in_ready_o;
  wire logic out_acc = out_valid_o & out_ready_i;
  wire logic is_r    = (cmd_q == CmdR);
  wire logic is_s    = (cmd_q == CmdS);
  wire logic is_w    = (cmd_q == CmdW);
  wire logic is_x    = (cmd_q == CmdX);
  // effective payload length, capped at FrameDataMax
  wire logic [4:0] len_eff = (len_q > 5'(FrameDataMax)) ? 5'(FrameDataMax) : len_q;
  // emitted reply payload length, 8 bits
  wire logic [7:0] rlen = is_r ? {2'b0, len_eff, 1'b0} : 8'(len_eff) * 8'd3;
  // output slot is free or being freed this cycle
  wire logic oslot = ~ovalid_q | out_ready_i;

  assign in_ready_o  = (state_q == ST_IDLE) & ~ovalid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign kind_o      = okind_q;
  assign out_byte_o  = obyte_q;
  assign last_o      = olast_q;

  // header byte selection for the reply
  logic [7:0] hdr_byte;
  always_comb begin
    case (hdr_q)
      3'd0:    hdr_byte = Head1Byte;
      3'd1:    hdr_byte = Head2Byte;
      3'd2:    hdr_byte = dst_q;
      3'd3:    hdr_byte = src_q;
      3'd4:    hdr_byte = rcmd_q;
      default: hdr_byte = rlen;
    endcase
  end

  // control signals of the sequencer
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_kind, emit_last;
  logic [4:0] j_d;
  logic [2:0] hdr_d;
  logic [7:0] off_d, rsum_d;
  logic [4:0] len_d, cnt_d;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    sum_d     = sum_q;
    j_d       = j_q;
    hdr_d     = hdr_q;
    off_d     = off_q;
    rsum_d    = rsum_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    pay_we    = 1'b0;
    pay_addr  = j_q[PayAw-1:0];
    pay_wdata = byte_value_i;
    reg_we    = 1'b0;
    reg_addr  = off_q[RegAw-1:0];
    reg_wdata = pay_rdata;
    emit      = 1'b0;
    emit_byte = reg_rdata;
    emit_kind = 1'b0;
    emit_last = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        reg_we    = 1'b1;
        reg_addr  = clr_q[RegAw-1:0];
        reg_wdata = 8'h00;
        if (clr_q == (RegAw+1)'(RegSpaceBytes - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (op_e'(operation_i))
            OP_WRITE: begin
              reg_we    = 1'b1;
              reg_addr  = local_offset_i[RegAw-1:0];
              reg_wdata = byte_value_i;
            end
            OP_READ: begin
              reg_addr = local_offset_i[RegAw-1:0];
              state_d  = ST_LOCRD;
            end
            OP_BUS: begin
              case (phase_q)
                PH_IDLE:  phase_d = (byte_value_i == Head1Byte) ? PH_HEAD1 : PH_IDLE;
                PH_HEAD1: begin
                  if (byte_value_i == Head2Byte) begin
                    phase_d = PH_HEAD2;
                  end else if (byte_value_i != Head1Byte) begin
                    phase_d = PH_IDLE;
                  end
                end
                PH_HEAD2: phase_d = PH_SRC;
                PH_SRC:   phase_d = PH_DST;
                PH_DST:   phase_d = PH_CMD;
                PH_CMD: begin
                  if (byte_value_i <= 8'(FrameDataMax)) begin
                    len_d   = byte_value_i[4:0];
                    cnt_d   = 5'd0;
                    phase_d = (byte_value_i == 8'd0) ? PH_CKSUM : PH_DATA;
                  end else begin
                    phase_d = PH_IDLE;
                  end
                end
                PH_DATA: begin
                  if (cnt_q < 5'(FrameDataMax)) begin
                    pay_we   = 1'b1;
                    pay_addr = cnt_q[PayAw-1:0];
                  end
                  cnt_d = cnt_q + 5'd1;
                  if (cnt_q + 5'd1 >= len_q) begin
                    phase_d = PH_CKSUM;
                  end
                end
                PH_CKSUM: begin
                  phase_d = PH_IDLE;
                  sum_d   = Head1Byte + Head2Byte + src_q + dst_q + cmd_q
                            + {3'b0, len_q} + byte_value_i;
                  j_d     = 5'd0;
                  pay_addr = '0;
                  state_d = (len_eff == 5'd0) ? ST_SUMW : ST_SUM;
                end
                default: phase_d = PH_IDLE;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_LOCRD: begin
        emit      = 1'b1;
        emit_kind = 1'b1;
        emit_last = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc | ~ovalid_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        // pay_rdata holds entry j_q
        sum_d    = sum_q + pay_rdata;
        j_d      = j_q + 5'd1;
        pay_addr = PayAw'(j_q + 5'd1);
        if (j_q + 5'd1 == len_eff) begin
          state_d = ST_SUMW;
        end
      end
      ST_SUMW: begin
        j_d   = 5'd0;
        hdr_d = 3'd0;
        rsum_d = 8'd0;
        if (sum_q != 8'd0) begin
          state_d = ST_IDLE;
        end else if (dst_q != node_q && dst_q != bcast_q) begin
          state_d = ST_IDLE;
        end else if (is_r || is_s) begin
          state_d = ST_HDR;
        end else if ((is_w && len_eff >= 5'd2) || (is_x && len_eff >= 5'd3)) begin
          pay_addr = '0;
          state_d  = ST_EXOFF;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (oslot) begin
          emit      = 1'b1;
          emit_byte = hdr_byte;
          rsum_d    = rsum_q + hdr_byte;
          hdr_d     = hdr_q + 3'd1;
          if (hdr_q == 3'd5) begin
            j_d      = 5'd0;
            pay_addr = '0;
            state_d  = (len_eff == 5'd0) ? ST_CKO : ST_EXOFF;
          end
        end
      end
      ST_EXRD: begin
        pay_addr = j_q[PayAw-1:0];
        state_d  = ST_EXOFF;
      end
      ST_EXOFF: begin
        // pay_rdata = offset at entry j_q
        off_d = pay_rdata;
        if (is_r || is_s) begin
          if (oslot) begin
            emit      = 1'b1;
            emit_byte = pay_rdata;
            rsum_d    = rsum_q + pay_rdata;
            reg_addr  = pay_rdata[RegAw-1:0];
            state_d   = ST_EXV1;
          end
        end else begin
          pay_addr = PayAw'(j_q + 5'd1);
          state_d  = ST_EXV1;
        end
      end
      ST_EXV1: begin
        if (is_r || is_s) begin
          if (oslot) begin
            emit      = 1'b1;
            rsum_d    = rsum_q + reg_rdata;
            if (is_s) begin
              reg_addr = RegAw'(off_q + 8'd1);
              state_d  = ST_EXV2;
            end else begin
              j_d      = j_q + 5'd1;
              pay_addr = PayAw'(j_q + 5'd1);
              state_d  = (j_q + 5'd1 == len_eff) ? ST_CKO : ST_EXOFF;
            end
          end
        end else begin
          reg_we = 1'b1;   // low byte / W value
          if (is_x) begin
            pay_addr = PayAw'(j_q + 5'd2);
            state_d  = ST_EXV2;
          end else begin
            j_d      = j_q + 5'd2;
            pay_addr = PayAw'(j_q + 5'd2);
            state_d  = (j_q + 5'd3 < len_eff) ? ST_EXOFF : ST_IDLE;
          end
        end
      end
      ST_EXV2: begin
        if (is_s) begin
          // keep the high byte address while the output is stalled
          reg_addr = RegAw'(off_q + 8'd1);
          if (oslot) begin
            emit     = 1'b1;
            rsum_d   = rsum_q + reg_rdata;
            j_d      = j_q + 5'd1;
            pay_addr = PayAw'(j_q + 5'd1);
            state_d  = (j_q + 5'd1 == len_eff) ? ST_CKO : ST_EXOFF;
          end
        end else begin
          // hold the high byte entry for the write
          pay_addr = PayAw'(j_q + 5'd2);
          state_d  = ST_EXV3;
        end
      end
      ST_EXV3: begin
        reg_we   = 1'b1;
        reg_addr = RegAw'(off_q + 8'd1);
        j_d      = j_q + 5'd3;
        pay_addr = PayAw'(j_q + 5'd3);
        state_d  = (j_q + 5'd6 <= len_eff) ? ST_EXRD : ST_IDLE;
      end
      ST_CKO: begin
        if (oslot) begin
          emit      = 1'b1;
          emit_byte = 8'd0 - rsum_q;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      phase_q  <= PH_IDLE;
      clr_q    <= '0;
      node_q   <= 8'd0;
      bcast_q  <= 8'hFF;
      src_q    <= 8'd0;
      dst_q    <= 8'd0;
      cmd_q    <= 8'd0;
      len_q    <= 5'd0;
      cnt_q    <= 5'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_NODE:  node_q  <= cfg_data_i;
          CFG_BCAST: bcast_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc && op_e'(operation_i) == OP_BUS) begin
        if (phase_q == PH_HEAD2) src_q <= byte_value_i;
        if (phase_q == PH_SRC)   dst_q <= byte_value_i;
        if (phase_q == PH_DST)   cmd_q <= byte_value_i;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_acc) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    j_q    <= j_d;
    hdr_q  <= hdr_d;
    off_q  <= off_d;
    rsum_q <= rsum_d;
    rcmd_q <= is_r ? CmdW : CmdX;
    if (emit) begin
      okind_q <= emit_kind;
      obyte_q <= emit_byte;
      olast_q <= emit_last;
    end
  end

  // an emitted byte never overwrites one not yet taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (~ovalid_q | out_ready_i))
    else $error("output register overrun");

  // input only taken when the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE)
    else $error("input taken while busy");

  // a local read yields data in the output register after ST_LOCRD
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOCRD) |=> (ovalid_q && okind_q && olast_q))
    else $error("local read result missing");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the serial frame register access node: framed and local traffic
`timescale 1ns / 1ps
module tb;
  import sfran_pkg::*;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // dut ports, all inputs driven to known values from time zero
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] operation_i = OP_BUS;
  logic [7:0] byte_value_i = '0;
  logic [7:0] local_offset_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       kind_o;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = CFG_NODE;
  logic [7:0] cfg_data_i = '0;

  serial_frame_register_access_node dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .byte_value_i,
    .local_offset_i, .out_valid_o, .out_ready_i, .kind_o, .out_byte_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // one outgoing transaction as the checker sees it
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } node_out_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEAD1, PH_HEAD2, PH_SRC, PH_DST, PH_CMD, PH_DATA, PH_CKSUM
  } phase_e;

  // shadow of the node: configuration, parser and register space
  logic [7:0] my_node, my_bcast;
  phase_e     ph;
  logic [7:0] f_src, f_dst, f_cmd;
  logic [4:0] f_len, f_cnt;
  logic [7:0] f_pay [FrameDataMax];
  logic [7:0] regs [RegSpaceBytes];

  node_out_t expected_q[$];
  int errors = 0;
  int n_items = 0;
  int n_outs = 0;
  int n_frames = 0;
  int cycles = 0;
  int src_idle = 0;   // percent
  int dst_stall = 0;  // percent

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // reply frame with checksum, appended to the expectation queue
  task automatic queue_reply(input logic [7:0] cmd, input logic [7:0] body[$]);
    logic [7:0] fr[$];
    logic [7:0] sum;
    sum = '0;
    fr = {Head1Byte, Head2Byte, f_dst, f_src, cmd, 8'(body.size())};
    foreach (body[i]) fr.push_back(body[i]);
    foreach (fr[i]) sum += fr[i];
    fr.push_back(8'(-sum));
    foreach (fr[i]) expected_q.push_back('{1'b0, fr[i], i == fr.size() - 1});
  endtask

  task automatic run_frame();
    logic [7:0] body[$];
    int n;
    n = (f_len > FrameDataMax) ? FrameDataMax : f_len;
    if (f_cmd == CmdW) begin
      for (int j = 0; j + 1 < n; j += 2) regs[f_pay[j]] = f_pay[j+1];
    end else if (f_cmd == CmdX) begin
      for (int j = 0; j + 2 < n; j += 3) begin
        regs[f_pay[j]] = f_pay[j+1];
        regs[8'(f_pay[j] + 8'd1)] = f_pay[j+2];
      end
    end else if (f_cmd == CmdR) begin
      for (int j = 0; j < n; j++) begin
        body.push_back(f_pay[j]);
        body.push_back(regs[f_pay[j]]);
      end
      queue_reply(CmdW, body);
    end else if (f_cmd == CmdS) begin
      for (int j = 0; j < n; j++) begin
        body.push_back(f_pay[j]);
        body.push_back(regs[f_pay[j]]);
        body.push_back(regs[8'(f_pay[j] + 8'd1)]);
      end
      queue_reply(CmdX, body);
    end
  endtask

  // predicts the node's response to one accepted input transaction
  task automatic predict_node(input op_e op, input logic [7:0] b, input logic [7:0] off);
    logic [7:0] sum;
    case (op)
      OP_WRITE: regs[off] = b;
      OP_READ:  expected_q.push_back('{1'b1, regs[off], 1'b1});
      OP_BUS: begin
        case (ph)
          PH_IDLE:  ph = (b == Head1Byte) ? PH_HEAD1 : PH_IDLE;
          PH_HEAD1: begin
            if (b == Head2Byte) ph = PH_HEAD2;
            else if (b != Head1Byte) ph = PH_IDLE;
          end
          PH_HEAD2: begin f_src = b; ph = PH_SRC; end
          PH_SRC:   begin f_dst = b; ph = PH_DST; end
          PH_DST:   begin f_cmd = b; ph = PH_CMD; end
          PH_CMD: begin
            if (b <= FrameDataMax) begin
              f_len = b[4:0];
              f_cnt = '0;
              ph = (b == 0) ? PH_CKSUM : PH_DATA;
            end else ph = PH_IDLE;
          end
          PH_DATA: begin
            if (f_cnt < FrameDataMax) f_pay[f_cnt[3:0]] = b;
            f_cnt = f_cnt + 5'd1;
            if (f_cnt >= f_len) ph = PH_CKSUM;
          end
          PH_CKSUM: begin
            ph = PH_IDLE;
            sum = Head1Byte + Head2Byte + f_src + f_dst + f_cmd + 8'(f_len) + b;
            for (int j = 0; j < f_len && j < FrameDataMax; j++) sum += f_pay[j];
            if (sum == 0 && (f_dst == my_node || f_dst == my_bcast)) begin
              n_frames++;
              run_frame();
            end
          end
          default: ph = PH_IDLE;
        endcase
      end
      default: ;
    endcase
  endtask

  // sends one input transaction, with random idle cycles ahead of it;
  // valid stays up until the next falling edge, where the next step takes over
  task automatic send_item(input op_e op, input logic [7:0] b, input logic [7:0] off);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    byte_value_i <= b;
    local_offset_i <= off;
    do @(posedge clk_i); while (!in_ready_o);
    predict_node(op, b, off);
    n_items++;
  endtask

  // builds a frame with a correct checksum unless told to spoil it
  task automatic send_frame(input logic [7:0] dst, input logic [7:0] cmd,
                            input logic [7:0] pay[$], input bit bad_sum = 0,
                            input int n_pre = 1);
    logic [7:0] fr[$];
    logic [7:0] sum;
    sum = '0;
    fr = {Head2Byte, 8'($urandom), dst, cmd, 8'(pay.size())};
    foreach (pay[i]) fr.push_back(pay[i]);
    sum = Head1Byte;
    foreach (fr[i]) sum += fr[i];
    fr.push_back(8'(-sum) ^ (bad_sum ? 8'(1 << $urandom_range(7)) : 8'd0));
    repeat (n_pre) send_item(OP_BUS, Head1Byte, 8'($urandom));
    foreach (fr[i]) send_item(OP_BUS, fr[i], 8'($urandom));
  endtask

  // drops valid, waits for every expected result, then a margin for in-flight work
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // register writes only while the node is quiet
  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_NODE) my_node = val; else my_bcast = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker: rising-edge sample, random stall at the falling edge
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= dst_stall);

  always @(posedge clk_i) begin
    node_out_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{kind_o, out_byte_o, last_o};
      n_outs++;
      if (expected_q.size() == 0) report($sformatf("unexpected output %p", got));
      else begin
        want = expected_q.pop_front();
        if (got.kind !== want.kind) report($sformatf("kind %b want %b", got.kind, want.kind));
        if (got.data !== want.data)
          report($sformatf("byte %h want %h", got.data, want.data));
        if (got.last !== want.last) report($sformatf("last %b want %b", got.last, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  // directed: local ops, all commands, wrap, odd tails, bad frames
  task automatic test_directed();
    logic [7:0] p[$];
    send_item(OP_READ, 8'h00, 8'hFF);
    send_item(OP_WRITE, 8'hA5, 8'hFF);
    send_item(OP_WRITE, 8'h5A, 8'h00);
    send_item(OP_NONE, 8'hFF, 8'hFF);
    send_item(OP_READ, 8'h00, 8'hFF);
    // X at offset 0xff: high byte wraps to offset 0, trailing odd bytes ignored
    p = {8'hFF, 8'h11, 8'h22, 8'h33};
    send_frame(my_node, CmdX, p, 0, 3);
    p = {8'h10, 8'h77, 8'h20};
    send_frame(my_bcast, CmdW, p);
    p = {8'hFF, 8'h10, 8'h20};
    send_frame(my_node, CmdS, p);
    p = {};
    send_frame(my_node, CmdR, p);
    // length over the limit, bad checksum, foreign address, unknown command
    send_item(OP_BUS, Head1Byte, 8'h0);
    send_item(OP_BUS, Head2Byte, 8'h0);
    send_item(OP_BUS, 8'h01, 8'h0);
    send_item(OP_BUS, my_node, 8'h0);
    send_item(OP_BUS, CmdR, 8'h0);
    send_item(OP_BUS, 8'd17, 8'h0);
    p = {8'h10};
    send_frame(my_node, CmdR, p, 1);
    send_frame(my_node ^ 8'h01, CmdR, p);
    send_frame(my_node, 8'h41, p);
    // longest reply
    p = {};
    repeat (FrameDataMax) p.push_back(rnd_byte());
    send_frame(my_node, CmdS, p);
  endtask

  // random frames with random content plus noise and broken frames
  task automatic test_random(input int n);
    logic [7:0] p[$];
    logic [7:0] cmds[4];
    int len, r;
    cmds = '{CmdW, CmdX, CmdR, CmdS};
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        p = {};
        len = ($urandom_range(9) == 0) ? FrameDataMax : $urandom_range(6);
        repeat (len) p.push_back(rnd_byte());
        send_frame(($urandom_range(3) == 0) ? my_bcast :
                   ($urandom_range(5) == 0) ? rnd_byte() : my_node,
                   ($urandom_range(9) == 0) ? rnd_byte() : cmds[$urandom_range(3)],
                   p, $urandom_range(9) == 0, $urandom_range(1, 2));
      end else if (r < 70) send_item(OP_WRITE, rnd_byte(), rnd_byte());
      else if (r < 85) send_item(OP_READ, rnd_byte(), rnd_byte());
      else send_item(op_e'($urandom_range(3)), rnd_byte(), rnd_byte());
    end
  endtask

  initial begin
    my_node = 8'h00;
    my_bcast = 8'hFF;
    ph = PH_IDLE;
    {f_src, f_dst, f_cmd, f_len, f_cnt} = '0;
    foreach (regs[i]) regs[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    // hold off sending until everything has come back
    wait_drained();
    write_cfg(CFG_NODE, 8'h3C);
    write_cfg(CFG_BCAST, 8'hC3);
    src_idle = 56;
    test_random(2);
    src_idle = 0;
    dst_stall = 56;
    test_random(2);
    src_idle = 20;
    dst_stall = 20;
    write_cfg(CFG_NODE, 8'h00);
    write_cfg(CFG_BCAST, 8'hFF);
    test_random(2);
    src_idle = 0;
    dst_stall = 0;

    wait_drained();
    $display("covered %0d input items, %0d results, %0d frames executed",
             n_items, n_outs, n_frames);
    $display("local access, all four commands, wrap, bad frames and four idle mixes");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
